[design/lkst_pkg.sv]
// Shared types and constants for the link keepalive and subscription timer.
// Used by lkst_step and link_keepalive_subscription_timer; no dependencies.
`timescale 1ns / 1ps

package lkst_pkg;

  // Message kinds carried in the input tuser.
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_PING     = 3'd1;
  localparam logic [2:0] MODE_SUB_REQ  = 3'd2;
  localparam logic [2:0] MODE_DEV_WR   = 3'd3;
  localparam logic [2:0] MODE_UNRECOG  = 3'd4;
  localparam logic [2:0] MODE_READ_ERR = 3'd5;

  // Error codes reported with each result.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNRECOG = 2'd1;
  localparam logic [1:0] ERR_READ    = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL = 2'd1;

  // Subscription interval clamp limits in ms.
  localparam logic [15:0] SUB_INTERVAL_MAX = 16'd500;
  localparam logic [15:0] SUB_INTERVAL_MIN = 16'd40;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  mode;
    logic [31:0] sub_bitmap;
    logic [15:0] sub_interval_req;
  } item_t;

  typedef struct packed {
    logic        send_ack;
    logic        send_data;
    logic [31:0] data_bitmap;
    logic        send_ping;
    logic        disable_pulse;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic        acked;
    logic [31:0] sub_map;
    logic [8:0]  data_interval;
    logic [31:0] last_data_time;
    logic [31:0] last_ping_sent_time;
    logic [31:0] last_ping_rx_time;
  } link_state_t;

endpackage

[design/link_keepalive_subscription_timer.sv]
// Top level of the link keepalive and subscription timer: stream ports,
// input register, state and result register. Depends on lkst_pkg and lkst_step.
`timescale 1ns / 1ps

// Each input word carries the current millisecond time and an optional
// received message and produces exactly one result word. The block takes
// one word per clock cycle while the result stream is not stalled. A word
// passes through the input register, then the single compute stage in
// which the message handling and the three elapsed-time checks update the
// link state, and then the result register. While a finished result waits
// in the output register, the input register can still take one more word;
// after that the input stalls until the result is taken. Configuration is
// written through the cfg port (index 0 timeout_ms, index 1 ping_interval_ms;
// other indexes are ignored) and should only be changed while no word is in
// flight.
module link_keepalive_subscription_timer (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // now_ms[31:0], sub_bitmap[63:32], sub_interval_req[79:64]
  input  logic [2:0]  s_tuser,  // mode[2:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // send_ack[0], send_data[1], data_bitmap[33:2],
                                // send_ping[34], disable_pulse[35], error_code[37:36]
);
  import lkst_pkg::*;

  logic [31:0] timeout_ms;
  logic [31:0] ping_interval_ms;
  logic        s1_valid;
  item_t       s1_item;
  logic        s1_adv;
  link_state_t st;
  link_state_t st_next;
  result_t     step_res;
  logic        out_valid;
  result_t     out_res;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms       <= '0;
      ping_interval_ms <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT:       timeout_ms       <= cfg_data;
        CFG_PING_INTERVAL: ping_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The compute stage advances whenever the result register is free or draining.
  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_item.now_ms           <= s_tdata[31:0];
      s1_item.mode             <= s_tuser;
      s1_item.sub_bitmap       <= s_tdata[63:32];
      s1_item.sub_interval_req <= s_tdata[79:64];
    end
  end

  lkst_step u_step (
    .st               (st),
    .timeout_ms       (timeout_ms),
    .ping_interval_ms (ping_interval_ms),
    .item             (s1_item),
    .st_next          (st_next),
    .res              (step_res)
  );

  // Link state and result register update together as a word leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        st <= st_next;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.error_code, out_res.disable_pulse, out_res.send_ping,
                     out_res.data_bitmap, out_res.send_data, out_res.send_ack};

endmodule

[design/lkst_step.sv]
// Combinational step of the keepalive timer: message handling and the three timers.
// Depends on lkst_pkg for the item, result and state types.
`timescale 1ns / 1ps

module lkst_step (
  input  lkst_pkg::link_state_t st,
  input  logic [31:0]           timeout_ms,
  input  logic [31:0]           ping_interval_ms,
  input  lkst_pkg::item_t       item,
  output lkst_pkg::link_state_t st_next,
  output lkst_pkg::result_t     res
);
  import lkst_pkg::*;

  link_state_t mid;
  logic [15:0] req_clamped;
  logic [31:0] data_age;
  logic [31:0] ping_age;
  logic [31:0] rx_age;
  logic        data_due;
  logic        ping_due;
  logic        timed_out;

  // Clamp the requested data interval to the supported range.
  always_comb begin
    if (item.sub_interval_req > SUB_INTERVAL_MAX) begin
      req_clamped = SUB_INTERVAL_MAX;
    end else if (item.sub_interval_req < SUB_INTERVAL_MIN) begin
      req_clamped = SUB_INTERVAL_MIN;
    end else begin
      req_clamped = item.sub_interval_req;
    end
  end

  // Message handling comes first; the timers see its effect.
  always_comb begin
    mid            = st;
    res            = '0;
    res.error_code = ERR_NONE;
    case (item.mode) inside
      MODE_NONE, MODE_DEV_WR: begin
      end
      MODE_PING: begin
        mid.last_ping_rx_time = item.now_ms;
        if (!st.acked) begin
          res.send_ack = 1'b1;
          mid.acked    = 1'b1;
        end
      end
      MODE_SUB_REQ: begin
        mid.sub_map       = item.sub_bitmap;
        mid.data_interval = req_clamped[8:0];
      end
      MODE_READ_ERR: res.error_code = ERR_READ;
      default:       res.error_code = ERR_UNRECOG;
    endcase

    // Elapsed times wrap modulo 2^32; a zero period never fires.
    data_age  = item.now_ms - mid.last_data_time;
    ping_age  = item.now_ms - mid.last_ping_sent_time;
    rx_age    = item.now_ms - mid.last_ping_rx_time;
    data_due  = (mid.data_interval != '0) && (data_age >= {23'd0, mid.data_interval});
    ping_due  = (ping_interval_ms != '0) && (ping_age >= ping_interval_ms);
    timed_out = (timeout_ms != '0) && (rx_age >= timeout_ms);

    st_next = mid;
    if (mid.acked) begin
      if (data_due) begin
        st_next.last_data_time = item.now_ms;
        res.send_data          = 1'b1;
        res.data_bitmap        = mid.sub_map;
      end
      if (ping_due) begin
        st_next.last_ping_sent_time = item.now_ms;
        res.send_ping               = 1'b1;
      end
      if (timed_out) begin
        st_next.acked     = 1'b0;
        res.disable_pulse = 1'b1;
      end
    end
  end

endmodule

[design/lkst_checker.sv]
// Port-level checks for link_keepalive_subscription_timer, attached by bind.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps

module lkst_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // The bitmap is only carried with a data message.
  a_bitmap_gated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[33:2] == 32'd0)
    else $error("data bitmap set without send_data");

  // The error code never takes its unused value, and the padding stays zero.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:36] != 2'd3 && m_tdata[39:38] == 2'd0)
    else $error("bad error code or padding");

  // A first-contact acknowledge cannot time out in the same word, and it only
  // comes from a ping, which reports no error.
  a_ack_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[35] && m_tdata[37:36] == 2'd0)
    else $error("acknowledge together with disable or error");

endmodule

bind link_keepalive_subscription_timer lkst_checker u_lkst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
